### hdl/tdrd_pkg.sv
package tdrd_pkg;

  localparam int MAX_TERM_CHARS = 1024;
  localparam int MAX_FIELDS     = 256;
  localparam int HEADER_BYTES   = 24;

  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_FORMAT    = 3'd1;
  localparam logic [2:0] ERR_SKIP      = 3'd2;
  localparam logic [2:0] ERR_LENGTHS   = 3'd3;
  localparam logic [2:0] ERR_NEG_FREQ  = 3'd4;
  localparam logic [2:0] ERR_FIELD     = 3'd5;
  localparam logic [2:0] ERR_TRUNCATED = 3'd6;

  localparam logic [1:0] REG_FORMAT      = 2'd0;
  localparam logic [1:0] REG_SKIP        = 2'd1;
  localparam logic [1:0] REG_FIELD_COUNT = 2'd2;

  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_PREFIX = 4'd1;
  localparam logic [3:0] PH_SUFFIX = 4'd2;
  localparam logic [3:0] PH_LEAD   = 4'd3;
  localparam logic [3:0] PH_CONT   = 4'd4;
  localparam logic [3:0] PH_FIELD  = 4'd5;
  localparam logic [3:0] PH_FREQ   = 4'd6;
  localparam logic [3:0] PH_FPTR   = 4'd7;
  localparam logic [3:0] PH_PPTR   = 4'd8;
  localparam logic [3:0] PH_SKIP   = 4'd9;
  localparam logic [3:0] PH_DONE   = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         char_position;
    logic [24:0]        char_code;
    logic [10:0]        prefix_length;
    logic [10:0]        term_length;
    logic [7:0]         fld_num;
    logic [30:0]        doc_frequency;
    logic signed [63:0] freq_pos;
    logic signed [63:0] prox_pos;
    logic signed [31:0] skip_ofs;
    logic [2:0]         error_code;
  } out_item_t;

  typedef struct packed {
    logic [31:0] expected_format;
    logic [30:0] skip_ivl;
    logic [8:0]  field_count;
  } cfg_regs_t;

endpackage

### hdl/tdrd_if.sv
interface tdrd_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/tdrd_cfg_if.sv
interface tdrd_cfg_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/tdrd_cfg_regs.sv
module tdrd_cfg_regs
  import tdrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  tdrd_cfg_if.sink  cfg,
  output cfg_regs_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expected_format <= '0;
      regs.skip_ivl        <= 31'd16;
      regs.field_count     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FORMAT:      regs.expected_format <= cfg.data;
        REG_SKIP:        regs.skip_ivl        <= cfg.data[30:0];
        REG_FIELD_COUNT: regs.field_count     <= cfg.data[8:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/tdrd_decoder.sv
module tdrd_decoder
  import tdrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t regs,
  input  logic      step,
  input  in_item_t  item,
  output logic      res_valid,
  output out_item_t res
);

  logic [3:0]  phase, phase_next;
  logic [4:0]  byte_counter, byte_counter_next;
  logic [63:0] word_acc, word_acc_next;
  logic [6:0]  vshift, vshift_next;
  logic [10:0] cur_len, cur_len_next;
  logic [10:0] suf_rem, suf_rem_next;
  logic [24:0] char_acc, char_acc_next;
  logic [1:0]  char_left, char_left_next;
  logic [31:0] rec_prefix, rec_prefix_next;
  logic [31:0] rec_field, rec_field_next;
  logic [31:0] rec_freq, rec_freq_next;
  logic [63:0] freq_ptr, freq_ptr_next;
  logic [63:0] prox_ptr, prox_ptr_next;
  logic [2:0]  err, err_next;

  logic [7:0]  b;
  logic [63:0] vacc;
  logic        vdone;
  logic [63:0] vshifted;
  logic [31:0] vlow;
  logic [32:0] len_sum;
  logic [8:0]  field_limit;
  logic [24:0] cont_acc;

  always_comb begin
    b = item.data_byte;
    vshifted = {57'd0, b[6:0]} << vshift[5:0];
    vacc = vshift[6] ? word_acc : (word_acc | vshifted);
    vdone = !b[7];
    vlow = vacc[31:0];
    len_sum = {1'b0, rec_prefix} + {1'b0, vlow};
    field_limit = (regs.field_count > 9'(MAX_FIELDS)) ? 9'(MAX_FIELDS) : regs.field_count;
    cont_acc = {char_acc[18:0], b[5:0]};
  end

  always_comb begin
    logic       emit;
    logic       fail;
    logic [2:0] fail_code;
    logic       do_char;
    logic [24:0] ccode;
    logic       do_rec;
    logic [31:0] rskip;
    logic [31:0] hword;
    logic [10:0] pos;
    phase_next = phase;
    byte_counter_next = byte_counter;
    word_acc_next = word_acc;
    vshift_next = vshift;
    cur_len_next = cur_len;
    suf_rem_next = suf_rem;
    char_acc_next = char_acc;
    char_left_next = char_left;
    rec_prefix_next = rec_prefix;
    rec_field_next = rec_field;
    rec_freq_next = rec_freq;
    freq_ptr_next = freq_ptr;
    prox_ptr_next = prox_ptr;
    err_next = err;
    emit = 1'b0;
    fail = 1'b0;
    fail_code = ERR_NONE;
    do_char = 1'b0;
    ccode = '0;
    do_rec = 1'b0;
    rskip = '0;
    hword = '0;
    pos = cur_len - suf_rem;
    res = '0;

    if (err != ERR_NONE) begin
      emit = 1'b1;
      fail = 1'b1;
      fail_code = err;
    end else if (phase == PH_DONE) begin
      emit = 1'b1;
      res.kind = KIND_END;
    end else begin
      // advance varint state by default; phases that finish reset it below
      unique case (phase)
        PH_HEADER: begin
          if (byte_counter == 5'd0 || byte_counter == 5'd16) begin
            hword = {24'd0, b};
            word_acc_next = {56'd0, b};
          end else if (byte_counter < 5'd4 || (byte_counter > 5'd16 && byte_counter < 5'd20))
              begin
            hword = {word_acc[23:0], b};
            word_acc_next = {word_acc[55:0], b};
          end else begin
            hword = word_acc[31:0];
          end
          if (byte_counter == 5'd3 && hword != regs.expected_format) begin
            fail = 1'b1;
            fail_code = ERR_FORMAT;
          end else begin
            if (byte_counter == 5'd19) rec_freq_next = hword;
            if (byte_counter == 5'(HEADER_BYTES - 1)) begin
              if (rec_freq != {1'b0, regs.skip_ivl}) begin
                fail = 1'b1;
                fail_code = ERR_SKIP;
              end else begin
                rec_freq_next = '0;
                phase_next = PH_PREFIX;
                word_acc_next = '0;
                vshift_next = '0;
              end
            end else begin
              byte_counter_next = byte_counter + 5'd1;
            end
          end
        end
        PH_PREFIX, PH_SUFFIX, PH_FIELD, PH_FREQ, PH_FPTR, PH_PPTR, PH_SKIP: begin
          if (!vdone) begin
            word_acc_next = vacc;
            vshift_next = vshift[6] ? vshift : vshift + 7'd7;
          end else begin
            word_acc_next = '0;
            vshift_next = '0;
            unique case (phase)
              PH_PREFIX: begin
                rec_prefix_next = vlow;
                phase_next = PH_SUFFIX;
              end
              PH_SUFFIX: begin
                if (rec_prefix[31] || vlow[31] || rec_prefix > {21'd0, cur_len} ||
                    len_sum > 33'(MAX_TERM_CHARS)) begin
                  fail = 1'b1;
                  fail_code = ERR_LENGTHS;
                end else begin
                  cur_len_next = len_sum[10:0];
                  suf_rem_next = vlow[10:0];
                  phase_next = (vlow == 32'd0) ? PH_FIELD : PH_LEAD;
                end
              end
              PH_FIELD: begin
                rec_field_next = vlow;
                phase_next = PH_FREQ;
              end
              PH_FREQ: begin
                rec_freq_next = vlow;
                phase_next = PH_FPTR;
              end
              PH_FPTR: begin
                freq_ptr_next = freq_ptr + vacc;
                phase_next = PH_PPTR;
              end
              PH_PPTR: begin
                prox_ptr_next = prox_ptr + vacc;
                if (rec_freq[31]) begin
                  fail = 1'b1;
                  fail_code = ERR_NEG_FREQ;
                end else if (rec_freq >= {1'b0, regs.skip_ivl}) begin
                  phase_next = PH_SKIP;
                end else begin
                  do_rec = 1'b1;
                end
              end
              default: begin
                do_rec = 1'b1;
                rskip = vlow;
              end
            endcase
          end
        end
        PH_LEAD: begin
          priority if (!b[7]) begin
            do_char = 1'b1;
            ccode = {17'd0, b};
          end else if (b[7:5] == 3'b110) begin
            char_acc_next = {20'd0, b[4:0]};
            char_left_next = 2'd1;
            phase_next = PH_CONT;
          end else if (b[7:4] == 4'b1110) begin
            char_acc_next = {21'd0, b[3:0]};
            char_left_next = 2'd2;
            phase_next = PH_CONT;
          end else if (b[7:3] == 5'b11110) begin
            char_acc_next = {22'd0, b[2:0]};
            char_left_next = 2'd3;
            phase_next = PH_CONT;
          end else begin
            char_acc_next = {18'd0, b[6:0]};
            char_left_next = 2'd3;
            phase_next = PH_CONT;
          end
        end
        PH_CONT: begin
          char_acc_next = cont_acc;
          char_left_next = char_left - 2'd1;
          if (char_left == 2'd1) begin
            do_char = 1'b1;
            ccode = cont_acc;
          end
        end
        default: ;
      endcase

      if (do_char) begin
        emit = 1'b1;
        res.kind = KIND_CHAR;
        res.char_position = pos[9:0];
        res.char_code = ccode;
        res.prefix_length = rec_prefix[10:0];
        res.term_length = cur_len;
        suf_rem_next = suf_rem - 11'd1;
        phase_next = (suf_rem == 11'd1) ? PH_FIELD : PH_LEAD;
        if (suf_rem == 11'd1) begin
          word_acc_next = '0;
          vshift_next = '0;
        end
      end

      if (do_rec) begin
        if (rec_field >= {23'd0, field_limit}) begin
          fail = 1'b1;
          fail_code = ERR_FIELD;
        end else begin
          emit = 1'b1;
          res.kind = KIND_RECORD;
          res.prefix_length = rec_prefix[10:0];
          res.term_length = cur_len;
          res.fld_num = rec_field[7:0];
          res.doc_frequency = rec_freq[30:0];
          res.freq_pos = freq_ptr_next;
          res.prox_pos = prox_ptr_next;
          res.skip_ofs = rskip;
          phase_next = PH_PREFIX;
        end
      end

      if (!fail && item.last_byte) begin
        if (phase_next == PH_PREFIX && vshift_next == 7'd0) begin
          phase_next = PH_DONE;
          if (!emit) begin
            emit = 1'b1;
            res = '0;
            res.kind = KIND_END;
          end
        end else begin
          fail = 1'b1;
          fail_code = ERR_TRUNCATED;
        end
      end
    end

    if (fail) begin
      emit = 1'b1;
      err_next = fail_code;
      res = '0;
      res.kind = KIND_ERROR;
      res.error_code = fail_code;
    end
    res_valid = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      byte_counter <= '0;
      word_acc <= '0;
      vshift <= '0;
      cur_len <= '0;
      suf_rem <= '0;
      char_acc <= '0;
      char_left <= '0;
      rec_prefix <= '0;
      rec_field <= '0;
      rec_freq <= '0;
      freq_ptr <= '0;
      prox_ptr <= '0;
      err <= ERR_NONE;
    end else if (step) begin
      phase <= phase_next;
      byte_counter <= byte_counter_next;
      word_acc <= word_acc_next;
      vshift <= vshift_next;
      cur_len <= cur_len_next;
      suf_rem <= suf_rem_next;
      char_acc <= char_acc_next;
      char_left <= char_left_next;
      rec_prefix <= rec_prefix_next;
      rec_field <= rec_field_next;
      rec_freq <= rec_freq_next;
      freq_ptr <= freq_ptr_next;
      prox_ptr <= prox_ptr_next;
      err <= err_next;
    end
  end

endmodule

### hdl/term_dictionary_record_decoder_top.sv
// Term dictionary record decoder.
// Channels: "in" carries one stream byte per item (data_byte, last_byte),
// header first; "out" carries at most one result item per input item
// (character, record complete, end of stream or error); "cfg" writes the
// three registers (0 format word, 1 skip interval, 2 field count) and is
// always ready; write it only while the block is idle.
// Path: an input item is registered in the input register, decoded
// combinationally from it, and its result is written to the output
// register when the output is free.
// Throughput: one byte per cycle unless the receiver stalls, set by the
// single decode step between the input register and the output register.
// Reset: registers return to their reset values, the decoder expects a
// fresh header and both pipeline stages empty.
// When the receiver stalls, the output register holds its item and the
// input register fills; in then drops ready until the output moves.
// Errors are sticky: every later byte returns the same error item.
module term_dictionary_record_decoder_top
  import tdrd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  tdrd_stream_if.sink     in,
  tdrd_stream_if.source   out,
  tdrd_cfg_if.sink        cfg
);

  cfg_regs_t regs;
  in_item_t  hold;
  logic      hold_valid;
  logic      res_valid;
  out_item_t res;
  logic      step;
  logic      out_free;

  tdrd_cfg_regs u_cfg (.clk(clk), .rst(rst), .cfg(cfg), .regs(regs));

  assign out_free = !out.valid || out.ready;
  assign step = hold_valid && out_free;
  assign in.ready = !hold_valid || out_free;

  tdrd_decoder u_dec (
    .clk(clk), .rst(rst), .regs(regs), .step(step), .item(hold),
    .res_valid(res_valid), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in.ready) begin
      hold_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.ready && in.valid) hold <= in.payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (out_free) begin
      out.valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step) out.payload <= res;
  end

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.payload))
    else $error("output item changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !hold_valid |-> in.ready)
    else $error("input refused with empty stage");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.payload.kind == KIND_ERROR |-> out.payload.error_code != ERR_NONE)
    else $error("error item without code");

  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out.valid == $past(res_valid))
    else $error("result register missed a decode step");

endmodule
